>>> hw/rtl/h2n_pkg.sv
// Shared types and constants for the height-to-normal-map block.
// Used by h2n_lane and height_to_normal_map; depends on nothing else.
package h2n_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int WCFG_W    = 11;
    localparam int CFG_W     = 16;

    // Pipeline depth: stage 0 holds memory read data, stage NST-1 is the output register
    localparam int NST       = 13;
    // Search stages plus the encode stage of one component lane
    localparam int KBITS     = 7;
    localparam int LANE_ST   = KBITS + 1;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    // Request kinds on tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // z term is 255*256; squared, and scaled by 127^2 for the z lane
    localparam logic [49:0] DSQ   = 50'd4261478400;
    localparam logic [63:0] RHS_Z = 64'd68733385113600;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

endpackage

>>> hw/rtl/h2n_lane.sv
// One normal component: finds k with a bit-serial search on k*k*q against rhs.
// Depends on h2n_pkg; one register stage per bit of k, then an encode stage.
module h2n_lane (
    input  logic                        i_clk,
    input  logic [h2n_pkg::LANE_ST-1:0] i_en,
    input  logic [49:0]                 i_q,
    input  logic [63:0]                 i_rhs,
    input  logic                        i_neg,
    output logic [7:0]                  o_code
);
    import h2n_pkg::*;

    logic [KBITS-1:0] r_k   [KBITS];
    logic [63:0]      r_p   [KBITS];
    logic [56:0]      r_t   [KBITS];
    logic [49:0]      r_q   [KBITS];
    logic [63:0]      r_rhs [KBITS];
    logic             r_neg [KBITS];
    logic [7:0]       r_code;

    logic [KBITS-1:0] s_k   [KBITS];
    logic [63:0]      s_p   [KBITS];
    logic [56:0]      s_t   [KBITS];
    logic [49:0]      s_q   [KBITS];
    logic [63:0]      s_rhs [KBITS];
    logic             s_neg [KBITS];

    genvar g;
    generate
        for (g = 0; g < KBITS; g++) begin : g_step
            localparam int J = KBITS - 1 - g;
            logic [63:0] n_p;
            logic [56:0] n_t;
            logic        w_ok;

            // Source of this stage: lane inputs or the previous stage
            if (g == 0) begin : g_first
                assign s_k[g]   = '0;
                assign s_p[g]   = '0;
                assign s_t[g]   = '0;
                assign s_q[g]   = i_q;
                assign s_rhs[g] = i_rhs;
                assign s_neg[g] = i_neg;
            end else begin : g_next
                assign s_k[g]   = r_k[g-1];
                assign s_p[g]   = r_p[g-1];
                assign s_t[g]   = r_t[g-1];
                assign s_q[g]   = r_q[g-1];
                assign s_rhs[g] = r_rhs[g-1];
                assign s_neg[g] = r_neg[g-1];
            end

            // (k + 2^J)^2 q = k^2 q + 2^(J+1) k q + 2^(2J) q
            assign n_p  = s_p[g] + ({7'd0, s_t[g]} << (J + 1)) + ({14'd0, s_q[g]} << (2 * J));
            assign n_t  = s_t[g] + ({7'd0, s_q[g]} << J);
            assign w_ok = s_neg[g] ? (n_p < s_rhs[g]) : (n_p <= s_rhs[g]);

            // Keep the trial bit when the product stays in range
            always_ff @(posedge i_clk) begin
                if (i_en[g]) begin
                    r_q[g]   <= s_q[g];
                    r_rhs[g] <= s_rhs[g];
                    r_neg[g] <= s_neg[g];
                    if (w_ok) begin
                        r_k[g] <= s_k[g] | KBITS'(1 << J);
                        r_p[g] <= n_p;
                        r_t[g] <= n_t;
                    end else begin
                        r_k[g] <= s_k[g];
                        r_p[g] <= s_p[g];
                        r_t[g] <= s_t[g];
                    end
                end
            end
        end
    endgenerate

    logic [KBITS-1:0] w_k;
    logic [KBITS-1:0] w_kup;
    assign w_k   = r_k[KBITS-1];
    // Negative side wants the first k at or past the bound, capped at 127
    assign w_kup = (w_k == {KBITS{1'b1}}) ? w_k : w_k + KBITS'(1);

    // Encode as 128 + k or 128 - k
    always_ff @(posedge i_clk) begin
        if (i_en[LANE_ST-1]) begin
            if (r_neg[KBITS-1]) begin
                r_code <= 8'd128 - {1'b0, w_kup};
            end else begin
                r_code <= 8'd128 + {1'b0, w_k};
            end
        end
    end

    assign o_code = r_code;

endmodule

>>> hw/rtl/height_to_normal_map.sv
// Height map to normal map, forward differences with edge wraparound.
// Throughput: one request per cycle while the output is not stalled;
// pixel and drain requests both flow back to back.
// Empty pipeline stages fill even while the output register holds a result.
// Reset (synchronous, active low) clears counters, drain flag and stage valids;
// the row stores keep their contents and need no clearing pass.
module height_to_normal_map (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [h2n_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [7:0]                i_s_tdata,  // [7:0] height_sample
    input  logic                      i_s_tuser,  // [0] req_type
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [55:0]               o_m_tdata,  // [7:0] normal_x, [15:8] normal_y,
                                                  // [23:16] normal_z, [39:24] out_row,
                                                  // [49:40] out_column, [55:50] zero
    output logic                      o_m_tlast   // last_in_frame
);
    import h2n_pkg::*;

    // Configuration registers
    logic [WCFG_W-1:0] r_width;
    logic [ROW_W-1:0]  r_height;
    logic [CFG_W-1:0]  r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WCFG_W'(512);
            r_height <= ROW_W'(512);
            r_scale  <= CFG_W'(768);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data[WCFG_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                REG_SCALE:  r_scale  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when the next one loads
    logic [NST-1:0] w_en;
    logic           r_v    [NST];
    t_meta          r_meta [NST];

    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || i_m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    assign o_s_tready = w_en[0];

    // Frame walk state
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_pend;
    logic [7:0]       r_head;   // column 0 of the newest input row
    logic [7:0]       r_saved;  // column 0 of the row above, kept after overwrite

    logic [WCFG_W-1:0] w_weff;
    logic [ROW_W-1:0]  w_heff;
    logic              w_acc;
    logic              w_drain;
    logic              w_row_end;
    logic              w_frame_end;
    logic              w_pix;
    logic              w_emit;
    logic [COL_W-1:0]  w_col_nx;
    logic [7:0]        n_saved;
    logic [7:0]        w_xreg;
    t_meta             w_meta;

    assign w_weff = (r_width == '0) ? WCFG_W'(1) :
                    (r_width > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH) : r_width;
    assign w_heff = (r_height == '0) ? ROW_W'(1) : r_height;

    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_drain     = (i_s_tuser == REQ_DRAIN);
    assign w_row_end   = ({1'b0, r_col} + WCFG_W'(1)) >= w_weff;
    assign w_frame_end = ({1'b0, r_row} + 17'd1) >= {1'b0, w_heff};
    assign w_pix       = w_acc && !w_drain && !r_pend;
    assign w_emit      = w_drain ? r_pend : (!r_pend && (r_row != '0));
    assign w_col_nx    = r_col + COL_W'(1);
    assign n_saved     = (r_col == '0) ? r_head : r_saved;

    // Right neighbour when it does not come from the store
    assign w_xreg = w_drain ? r_head : n_saved;

    always_comb begin
        w_meta.row  = w_drain ? r_row : r_row - ROW_W'(1);
        w_meta.col  = r_col;
        w_meta.last = w_drain && w_row_end;
    end

    // Advance counters on accepted requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= 1'b0;
        end else if (w_acc) begin
            if (w_drain && r_pend) begin
                if (w_row_end) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_pend <= 1'b0;
                end else begin
                    r_col <= w_col_nx;
                end
            end else if (w_pix) begin
                if (w_row_end) begin
                    r_col <= '0;
                    if (w_frame_end) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_col <= w_col_nx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saved <= '0;
        end else if (w_pix && (r_row != '0) && (r_col == '0)) begin
            r_saved <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pix && (r_col == '0)) begin
            r_head <= i_s_tdata;
        end
    end

    // Row stores: read old data and write the new sample at the same edge
    logic [7:0] r_prev_mem  [MAX_WIDTH];
    logic [7:0] r_first_mem [MAX_WIDTH];
    logic [7:0] r_rd_c;
    logic [7:0] r_rd_x;
    logic [7:0] r_rd_f;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rd_c <= r_prev_mem[r_col];
            r_rd_x <= r_prev_mem[w_col_nx];
        end
        if (w_pix) begin
            r_prev_mem[r_col] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rd_f <= r_first_mem[r_col];
        end
        if (w_pix && (r_row == '0)) begin
            r_first_mem[r_col] <= i_s_tdata;
        end
    end

    // Valid and position travel with each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_acc && w_emit;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_meta[0] <= w_meta;
        end
        for (int i = 1; i < NST; i++) begin
            if (w_en[i]) begin
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    // Stage 0 side data
    logic [7:0] r_smp;
    logic       r_drn;
    logic       r_xsel;
    logic [7:0] r_xreg;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_smp  <= i_s_tdata;
            r_drn  <= w_drain;
            r_xsel <= w_row_end;
            r_xreg <= w_xreg;
        end
    end

    // Stage 1: height differences
    logic [7:0]        w_cx;
    logic [7:0]        w_hy;
    logic signed [8:0] r_da;
    logic signed [8:0] r_db;

    assign w_cx = r_xsel ? r_xreg : r_rd_x;
    assign w_hy = r_drn ? r_rd_f : r_smp;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_da <= $signed({1'b0, r_rd_c}) - $signed({1'b0, w_hy});
            r_db <= $signed({1'b0, w_cx}) - $signed({1'b0, r_rd_c});
        end
    end

    // Stage 2: apply slope gain
    logic signed [24:0] r_a;
    logic signed [24:0] r_b;
    logic signed [25:0] w_pa;
    logic signed [25:0] w_pb;

    assign w_pa = r_da * $signed({1'b0, r_scale});
    assign w_pb = r_db * $signed({1'b0, r_scale});

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_a <= w_pa[24:0];
            r_b <= w_pb[24:0];
        end
    end

    // Stage 3: squares of the magnitudes
    logic [23:0] w_ma;
    logic [23:0] w_mb;
    logic [47:0] r_a2;
    logic [47:0] r_b2;
    logic        r_na3;
    logic        r_nb3;

    assign w_ma = r_a[24] ? 24'(-r_a) : r_a[23:0];
    assign w_mb = r_b[24] ? 24'(-r_b) : r_b[23:0];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_a2  <= w_ma * w_ma;
            r_b2  <= w_mb * w_mb;
            r_na3 <= r_a[24];
            r_nb3 <= r_b[24];
        end
    end

    // Stage 4: sum of squares and scaled bounds (16129 = 2^14 - 2^8 + 1)
    logic [49:0] r_q;
    logic [63:0] r_ra;
    logic [63:0] r_rb;
    logic        r_na;
    logic        r_nb;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_q  <= {2'b00, r_a2} + {2'b00, r_b2} + DSQ;
            r_ra <= ({16'd0, r_a2} << 14) - ({16'd0, r_a2} << 8) + {16'd0, r_a2};
            r_rb <= ({16'd0, r_b2} << 14) - ({16'd0, r_b2} << 8) + {16'd0, r_b2};
            r_na <= r_na3;
            r_nb <= r_nb3;
        end
    end

    // Stages 5 to 12: one search lane per component
    logic [7:0] w_nx;
    logic [7:0] w_ny;
    logic [7:0] w_nz;

    h2n_lane u_lane_x (
        .i_clk  (i_clk),
        .i_en   (w_en[NST-1 -: LANE_ST]),
        .i_q    (r_q),
        .i_rhs  (r_ra),
        .i_neg  (r_na),
        .o_code (w_nx)
    );

    h2n_lane u_lane_y (
        .i_clk  (i_clk),
        .i_en   (w_en[NST-1 -: LANE_ST]),
        .i_q    (r_q),
        .i_rhs  (r_rb),
        .i_neg  (r_nb),
        .o_code (w_ny)
    );

    h2n_lane u_lane_z (
        .i_clk  (i_clk),
        .i_en   (w_en[NST-1 -: LANE_ST]),
        .i_q    (r_q),
        .i_rhs  (RHS_Z),
        .i_neg  (1'b0),
        .o_code (w_nz)
    );

    assign o_m_tvalid = r_v[NST-1];
    assign o_m_tdata  = {6'd0, r_meta[NST-1].col, r_meta[NST-1].row, w_nz, w_ny, w_nx};
    assign o_m_tlast  = r_meta[NST-1].last;

`ifndef ASSERT_OFF
    // An empty first stage always takes a request
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> o_s_tready)
        else $error("input stalled with empty first stage");

    // A pixel during drain leaves no result
    a_drop_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_drain && r_pend) |=> !r_v[0])
        else $error("pixel during drain produced a result");

    // A drain request with nothing pending leaves no result
    a_drop_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_drain && !r_pend) |=> !r_v[0])
        else $error("idle drain produced a result");

    // Frame end is only flagged on drain results
    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && r_meta[0].last) |-> r_drn)
        else $error("last flag on a pixel result");
`endif

endmodule

>>> tb/tb_height_to_normal_map.sv
// Self-checking testbench for height_to_normal_map: drives height and drain requests,
// predicts every normal pixel in integer arithmetic and compares it on the master side.
// Depends on h2n_pkg and the height_to_normal_map RTL.
module tb_height_to_normal_map;
    timeunit 1ns;
    timeprecision 1ps;
    import h2n_pkg::*;

    localparam int  LINE_DEPTH  = MAX_WIDTH;
    localparam int  SETTLE_CYC  = NST + 8;
    localparam longint CYCLE_CAP = 1500000;

    typedef struct {
        logic [7:0]       nx;
        logic [7:0]       ny;
        logic [7:0]       nz;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } normal_px_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = REG_WIDTH;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata = '0;
    logic              i_s_tuser = REQ_PIXEL;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [55:0]       o_m_tdata;
    logic              o_m_tlast;

    height_to_normal_map dut (.*);

    // Predictor state
    logic [7:0]  prev_line [LINE_DEPTH];
    logic [7:0]  top_line [LINE_DEPTH];
    logic [7:0]  wrap_col0;
    int unsigned col_cnt, row_cnt;
    bit          draining;
    int unsigned cfg_w, cfg_h, cfg_scale;

    normal_px_t  normals_due[$];
    int          n_errors;
    int          send_idle_pct, recv_idle_pct;
    longint      cycle_cnt;
    int          sent_cnt;

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // floor(128 + 127*num/sqrt(q)) by searching the integer k
    function automatic logic [7:0] encode_normal(longint num, longint unsigned q);
        longint unsigned mag, rhs, k;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        rhs = 64'd16129 * mag * mag;
        if (num >= 0) begin
            k = 127;
            while (k > 0 && k * k * q > rhs) k--;
            return 8'(128 + k);
        end
        k = 0;
        while (k < 127 && k * k * q < rhs) k++;
        return 8'(128 - k);
    endfunction

    function automatic normal_px_t shade_pixel(int unsigned h, int unsigned hx, int unsigned hy,
                                               int unsigned row, int unsigned col, bit last);
        normal_px_t p;
        longint a, b;
        longint unsigned d, q;
        a = (longint'(h) - longint'(hy)) * longint'(cfg_scale);
        b = (longint'(hx) - longint'(h)) * longint'(cfg_scale);
        d = 65280;
        q = longint'(a * a) + longint'(b * b) + d * d;
        p.nx = encode_normal(a, q);
        p.ny = encode_normal(b, q);
        p.nz = encode_normal(longint'(d), q);
        p.row = row[ROW_W-1:0];
        p.col = col[COL_W-1:0];
        p.last = last;
        return p;
    endfunction

    // Advance the predictor by one accepted request
    task automatic predict_normals(logic kind, logic [7:0] h);
        int unsigned w, hh, cx, idx;
        bit row_end;
        w = (cfg_w == 0) ? 1 : (cfg_w > LINE_DEPTH ? LINE_DEPTH : cfg_w);
        hh = (cfg_h == 0) ? 1 : cfg_h;
        idx = col_cnt % LINE_DEPTH;
        row_end = (col_cnt + 1 >= w);
        if (kind == REQ_DRAIN) begin
            if (!draining) return;
            cx = row_end ? prev_line[0] : prev_line[(col_cnt + 1) % LINE_DEPTH];
            normals_due.push_back(shade_pixel(prev_line[idx], cx, top_line[idx],
                                              row_cnt, col_cnt, row_end));
            if (row_end) begin
                col_cnt = 0;
                row_cnt = 0;
                draining = 0;
            end else begin
                col_cnt++;
            end
            return;
        end
        if (draining) return;
        if (row_cnt == 0) begin
            top_line[idx] = h;
        end else begin
            if (col_cnt == 0) wrap_col0 = prev_line[0];
            cx = row_end ? wrap_col0 : prev_line[(col_cnt + 1) % LINE_DEPTH];
            normals_due.push_back(shade_pixel(prev_line[idx], cx, h,
                                              row_cnt - 1, col_cnt, 1'b0));
        end
        prev_line[idx] = h;
        if (row_end) begin
            col_cnt = 0;
            if (row_cnt + 1 >= hh) draining = 1;
            else row_cnt++;
        end else begin
            col_cnt++;
        end
    endtask

    // Result side: random stalls, compare against the oldest prediction
    always @(posedge i_clk) begin
        normal_px_t e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_m_tvalid && i_m_tready) begin
                if (normals_due.size() == 0) begin
                    $error("unexpected result: tdata=%h tlast=%b", o_m_tdata, o_m_tlast);
                    n_errors++;
                end else begin
                    e = normals_due.pop_front();
                    if (o_m_tdata[7:0] !== e.nx) begin
                        $error("normal_x: expected %0d, actual %0d", e.nx, o_m_tdata[7:0]);
                        n_errors++;
                    end
                    if (o_m_tdata[15:8] !== e.ny) begin
                        $error("normal_y: expected %0d, actual %0d", e.ny, o_m_tdata[15:8]);
                        n_errors++;
                    end
                    if (o_m_tdata[23:16] !== e.nz) begin
                        $error("normal_z: expected %0d, actual %0d", e.nz, o_m_tdata[23:16]);
                        n_errors++;
                    end
                    if (o_m_tdata[39:24] !== e.row) begin
                        $error("out_row: expected %0d, actual %0d", e.row, o_m_tdata[39:24]);
                        n_errors++;
                    end
                    if (o_m_tdata[49:40] !== e.col) begin
                        $error("out_column: expected %0d, actual %0d", e.col,
                               o_m_tdata[49:40]);
                        n_errors++;
                    end
                    if (o_m_tlast !== e.last) begin
                        $error("last_in_frame: expected %0d, actual %0d", e.last, o_m_tlast);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Send one request, idling at random first
    task automatic send_request(logic kind, logic [7:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= h;
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        predict_normals(kind, h);
        sent_cnt++;
    endtask

    // Hold off until every prediction has been seen, then let the pipe settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = val & 16'h7FF;
            REG_HEIGHT: cfg_h = val & 16'hFFFF;
            REG_SCALE:  cfg_scale = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned s);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_SCALE, s);
    endtask

    // Push one whole frame plus its drain; extremes picks 0/255 heights often
    task automatic run_frame(bit extremes, bit noise);
        int unsigned n_px;
        logic [7:0] h;
        n_px = cfg_w * cfg_h;
        for (int unsigned i = 0; i < n_px; i++) begin
            h = 8'($urandom_range(255));
            if (extremes && $urandom_range(1)) h = $urandom_range(1) ? 8'hFF : 8'h00;
            if (noise && $urandom_range(99) < 4) send_request(REQ_DRAIN, 8'($urandom_range(255)));
            send_request(REQ_PIXEL, h);
        end
        for (int unsigned i = 0; i < cfg_w; i++) begin
            if (noise && $urandom_range(99) < 5) send_request(REQ_PIXEL, 8'($urandom_range(255)));
            send_request(REQ_DRAIN, 8'($urandom_range(255)));
        end
    endtask

    // Stray drains, pixels during drain, steep slopes, single-pixel frame
    task automatic test_edge_cases();
        set_frame(3, 2, 768);
        send_request(REQ_DRAIN, 8'h5A);
        send_request(REQ_PIXEL, 8'h00);
        send_request(REQ_PIXEL, 8'hFF);
        send_request(REQ_PIXEL, 8'h00);
        send_request(REQ_PIXEL, 8'hFF);
        send_request(REQ_PIXEL, 8'h00);
        send_request(REQ_PIXEL, 8'hFF);
        send_request(REQ_PIXEL, 8'hA5);
        send_request(REQ_DRAIN, 8'h00);
        send_request(REQ_PIXEL, 8'h33);
        send_request(REQ_DRAIN, 8'hFF);
        send_request(REQ_DRAIN, 8'h00);
        send_request(REQ_DRAIN, 8'h00);
        set_frame(1, 1, 256);
        send_request(REQ_PIXEL, 8'h80);
        send_request(REQ_DRAIN, 8'h00);
    endtask

    task automatic test_scale_extremes();
        set_frame(2, 2, 0);
        run_frame(1, 0);
        set_frame(2, 2, 65535);
        run_frame(1, 0);
        set_frame(4, 3, 1);
        run_frame(1, 0);
    endtask

    task automatic test_random_frames(int unsigned n_items);
        int unsigned start, w, h, s;
        start = sent_cnt;
        while (sent_cnt - start < n_items) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 5);
            case ($urandom_range(5))
                0: s = 0;
                1: s = 65535;
                2: s = 768;
                default: s = $urandom_range(65535);
            endcase
            set_frame(w, h, s);
            run_frame($urandom_range(3) == 0, 1);
        end
    endtask

    task automatic test_wide_row();
        set_frame(150, 2, $urandom_range(65535));
        run_frame(0, 0);
    endtask

    task automatic test_tall_frame();
        set_frame(1, 300, $urandom_range(65535));
        run_frame(1, 0);
    endtask

    initial begin
        cfg_w = 512;
        cfg_h = 512;
        cfg_scale = 768;
        col_cnt = 0;
        row_cnt = 0;
        draining = 0;
        wrap_col0 = '0;
        n_errors = 0;
        sent_cnt = 0;
        cycle_cnt = 0;
        send_idle_pct = 11;
        recv_idle_pct = 67;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_scale_extremes();
        test_random_frames(300);

        send_idle_pct = 67;
        recv_idle_pct = 11;
        test_random_frames(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(300);
        test_wide_row();
        test_tall_frame();

        wait_idle();
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/h2n_pkg.sv
hw/rtl/h2n_lane.sv
hw/rtl/height_to_normal_map.sv
tb/tb_height_to_normal_map.sv
